>>> hw/rtl/bvg_pkg.sv
// ----------------------------------------------------------------------------
// bvg_pkg
// Shared types and constants for the battery voltage gauge.
// ----------------------------------------------------------------------------
package bvg_pkg;

   localparam int SampleW  = 12;
   localparam int SumW     = 16;
   localparam int CountW   = 5;
   localparam int GainW    = 24;
   localparam int MvW      = 16;
   localparam int PctW     = 7;
   localparam int EmaW     = 24;
   localparam int DivNumW  = 33;
   localparam int DivDenW  = 24;
   localparam int DivStepW = 6;

   localparam logic [GainW-1:0] GainReset = 24'd105625;
   localparam logic [MvW-1:0]   FullReset = 16'd4200;
   localparam logic [MvW-1:0]   EmptyReset = 16'd3300;

   localparam logic [1:0] RegGain  = 2'd0;
   localparam logic [1:0] RegFull  = 2'd1;
   localparam logic [1:0] RegEmpty = 2'd2;

   localparam logic [CountW-1:0]   CountMax = 5'd31;
   localparam logic [SumW-1:0]     SumMax   = 16'hFFFF;
   localparam logic [EmaW-1:0]     EmaMax   = 24'hFFFFFF;
   localparam logic [PctW-1:0]     PctMax   = 7'd100;

   // divide by 5 as multiply by ceil(2^30 / 5), exact for 27-bit dividends
   localparam int                  EmaRecipW = 28;
   localparam int                  EmaShift  = 30;
   localparam logic [EmaRecipW-1:0] EmaRecip = 28'd214748365;

   typedef struct packed {
      logic [SumW-1:0]   sum;
      logic [CountW-1:0] count;
   } read_type;

   typedef struct packed {
      logic               start;
      logic [DivNumW-1:0] dividend;
      logic [DivDenW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DivNumW-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [GainW-1:0] gain;
      logic [MvW-1:0]   full;
      logic [MvW-1:0]   empty;
   } cfg_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL,
      BK_AVG_START,
      BK_AVG_WAIT,
      BK_EMA,
      BK_EMA_WAIT,
      BK_CLAMP,
      BK_PCT_MUL,
      BK_PCT_START,
      BK_PCT_WAIT,
      BK_OUT
   } back_state_type;

endpackage

>>> hw/rtl/battery_voltage_gauge_top.sv
// ----------------------------------------------------------------------------
// battery_voltage_gauge_top
// Averaged converter reads to smoothed battery millivolts and charge percent.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  req_     | in  | tvalid/tready    | tdata[11:0] sample, tuser sample_ok,
//           |     |                  | tlast last_sample
//  rsp_     | out | tvalid/tready    | tdata[15:0] battery_mv, [22:16] percent
//  csr_     | in  | psel/penable     | 0x0 gain q16, 0x4 full mv, 0x8 empty mv
//
//  One sample request per cycle into the front accumulator while the queue is not full.
//  A read with an ok sample makes two passes through the shared bit-serial
//  divider in the back end (one with full <= empty); the smoothing step is a
//  reciprocal multiply.
//  A two-read queue sits between front and back; req_tready drops while full.
//  Reset is synchronous and clears the accumulators, the average and queue.
// ----------------------------------------------------------------------------
module battery_voltage_gauge_top #(
   parameter int SAMPLES_PER_READ = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample, [15:12] zero
   input  logic        req_tuser,   // [0] sample_ok
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] battery_mv, [22:16] charge_percent, [23] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   bvg_pkg::cfg_type     cfg_ff, cfg_in;
   bvg_pkg::read_type    push_data;
   bvg_pkg::read_type    pop_data;
   bvg_pkg::div_req_type div_req;
   bvg_pkg::div_rsp_type div_rsp;
   logic                 push;
   logic                 pop;
   logic                 fifo_full;
   logic                 fifo_empty;
   logic                 req_accept;
   logic                 csr_write;
   logic [bvg_pkg::MvW-1:0]  rsp_mv;
   logic [bvg_pkg::PctW-1:0] rsp_pct;

   assign csr_pready = 1'b1;
   assign req_tready = !fifo_full;
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_tdata  = {1'b0, rsp_pct, rsp_mv};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            bvg_pkg::RegGain:  cfg_in.gain  = csr_pwdata[bvg_pkg::GainW-1:0];
            bvg_pkg::RegFull:  cfg_in.full  = csr_pwdata[bvg_pkg::MvW-1:0];
            bvg_pkg::RegEmpty: cfg_in.empty = csr_pwdata[bvg_pkg::MvW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
      case (csr_paddr[3:2])
         bvg_pkg::RegGain:  csr_prdata = 32'(cfg_ff.gain);
         bvg_pkg::RegFull:  csr_prdata = 32'(cfg_ff.full);
         bvg_pkg::RegEmpty: csr_prdata = 32'(cfg_ff.empty);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain  <= bvg_pkg::GainReset;
         cfg_ff.full  <= bvg_pkg::FullReset;
         cfg_ff.empty <= bvg_pkg::EmptyReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bvg_front #(
      .SAMPLES_PER_READ (SAMPLES_PER_READ)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .sample      (req_tdata[bvg_pkg::SampleW-1:0]),
      .sample_ok   (req_tuser),
      .last_sample (req_tlast),
      .push        (push),
      .push_data   (push_data)
   );

   bvg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   bvg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bvg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fifo_empty (fifo_empty),
      .fifo_data  (pop_data),
      .fifo_pop   (pop),
      .div_req    (div_req),
      .div_rsp    (div_rsp),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_mv     (rsp_mv),
      .rsp_pct    (rsp_pct)
   );

endmodule

>>> hw/rtl/bvg_fifo.sv
// ----------------------------------------------------------------------------
// bvg_fifo
// Two-entry queue of finished reads between front and back.
// ----------------------------------------------------------------------------
module bvg_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bvg_pkg::read_type push_data,
   input  logic              pop,
   output bvg_pkg::read_type pop_data,
   output logic              full,
   output logic              empty
);

   bvg_pkg::read_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] level_ff, level_in;

   assign full     = level_ff == 2'd2;
   assign empty    = level_ff == 2'd0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      level_in  = level_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/bvg_front.sv
// ----------------------------------------------------------------------------
// bvg_front
// Sums and counts ok samples, up to SAMPLES_PER_READ (at most 31) per read; queues each read that had an ok sample.
// ----------------------------------------------------------------------------
module bvg_front #(
   parameter int SAMPLES_PER_READ = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [bvg_pkg::SampleW-1:0]   sample,
   input  logic                          sample_ok,
   input  logic                          last_sample,
   output logic                          push,
   output bvg_pkg::read_type             push_data
);

   localparam int CapInt = (SAMPLES_PER_READ < 31) ? SAMPLES_PER_READ : 31;
   localparam logic [bvg_pkg::CountW-1:0] Cap = bvg_pkg::CountW'(CapInt);

   logic [bvg_pkg::SumW-1:0]   sum_ff, sum_in;
   logic [bvg_pkg::CountW-1:0] count_ff, count_in;
   logic [bvg_pkg::SumW:0]     sum_wide;
   logic [bvg_pkg::SumW-1:0]   sum_acc;
   logic [bvg_pkg::CountW-1:0] count_acc;
   logic                       take;

   always_comb begin
      take      = sample_ok && (count_ff < Cap);
      sum_wide  = {1'b0, sum_ff} + (bvg_pkg::SumW+1)'(sample);
      sum_acc   = sum_ff;
      count_acc = count_ff;
      if (take) begin
         sum_acc   = sum_wide[bvg_pkg::SumW] ? bvg_pkg::SumMax : sum_wide[bvg_pkg::SumW-1:0];
         count_acc = count_ff + 1'b1;
      end
      push            = accept && last_sample && (count_acc != '0);
      push_data.sum   = sum_acc;
      push_data.count = count_acc;
      sum_in          = sum_ff;
      count_in        = count_ff;
      if (accept) begin
         if (last_sample) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_acc;
            count_in = count_acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/bvg_div.sv
// ----------------------------------------------------------------------------
// bvg_div
// Restoring divider, one quotient bit per cycle, shared by the back end.
// ----------------------------------------------------------------------------
module bvg_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bvg_pkg::div_req_type div_req,
   output bvg_pkg::div_rsp_type div_rsp
);

   localparam logic [bvg_pkg::DivStepW-1:0] LastStep =
      bvg_pkg::DivStepW'(bvg_pkg::DivNumW - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [bvg_pkg::DivStepW-1:0]  step_ff, step_in;
   logic [bvg_pkg::DivNumW-1:0]   quo_ff, quo_in;
   logic [bvg_pkg::DivDenW-1:0]   rem_ff, rem_in;
   logic [bvg_pkg::DivDenW-1:0]   den_ff, den_in;
   logic [bvg_pkg::DivDenW:0]     trial;
   logic [bvg_pkg::DivDenW:0]     diff;
   logic                          fits;

   always_comb begin
      trial = {rem_ff, quo_ff[bvg_pkg::DivNumW-1]};
      fits  = trial >= {1'b0, den_ff};
      diff  = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[bvg_pkg::DivNumW-2:0], fits};
         rem_in  = fits ? diff[bvg_pkg::DivDenW-1:0] : trial[bvg_pkg::DivDenW-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      div_rsp.busy     = busy_ff;
      div_rsp.done     = done_ff;
      div_rsp.quotient = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

endmodule

>>> hw/rtl/bvg_back.sv
// ----------------------------------------------------------------------------
// bvg_back
// Sequencer: average, scale, smoothing, clamp and percent; result register.
// ----------------------------------------------------------------------------
module bvg_back (
   input  logic                        clock,
   input  logic                        reset,
   input  bvg_pkg::cfg_type            cfg,
   input  logic                        fifo_empty,
   input  bvg_pkg::read_type           fifo_data,
   output logic                        fifo_pop,
   output bvg_pkg::div_req_type        div_req,
   input  bvg_pkg::div_rsp_type        div_rsp,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bvg_pkg::MvW-1:0]     rsp_mv,
   output logic [bvg_pkg::PctW-1:0]    rsp_pct
);

   localparam int ProdW  = bvg_pkg::SumW + bvg_pkg::GainW;
   localparam int PnumW  = bvg_pkg::EmaW + bvg_pkg::PctW;
   localparam int EprodW = bvg_pkg::EmaW + 3 + bvg_pkg::EmaRecipW;

   bvg_pkg::back_state_type state_ff, state_in;

   bvg_pkg::read_type             rd_ff, rd_in;
   logic [ProdW-1:0]              prod_ff, prod_in;
   logic [bvg_pkg::EmaW-1:0]      v_ff, v_in;
   logic [bvg_pkg::EmaW-1:0]      ema_ff, ema_in;
   logic                          seeded_ff, seeded_in;
   logic [EprodW-1:0]             eprod_ff, eprod_in;
   logic [bvg_pkg::EmaW-1:0]      c_ff, c_in;
   logic [PnumW-1:0]              pnum_ff, pnum_in;
   logic [bvg_pkg::MvW-1:0]       mv_ff, mv_in;
   logic [bvg_pkg::PctW-1:0]      pct_ff, pct_in;
   logic                          out_valid_ff, out_valid_in;
   logic [bvg_pkg::MvW-1:0]       out_mv_ff, out_mv_in;
   logic [bvg_pkg::PctW-1:0]      out_pct_ff, out_pct_in;

   logic [ProdW:0]                avg_num;
   logic [bvg_pkg::EmaW+2:0]      ema_num;
   logic [bvg_pkg::EmaW-1:0]      hi;
   logic [bvg_pkg::EmaW-1:0]      lo;
   logic [bvg_pkg::EmaW-1:0]      c_hi;
   logic [bvg_pkg::EmaW:0]        mv_wide;
   logic [bvg_pkg::EmaW-1:0]      span;
   logic [PnumW:0]                pct_num;

   assign rsp_valid = out_valid_ff;
   assign rsp_mv    = out_mv_ff;
   assign rsp_pct   = out_pct_ff;

   always_comb begin
      hi      = {cfg.full, 8'd0};
      lo      = {cfg.empty, 8'd0};
      span    = hi - lo;
      avg_num = {1'b0, prod_ff} + (ProdW+1)'({rd_ff.count, 7'd0});
      ema_num = (bvg_pkg::EmaW+3)'({ema_ff, 2'd0}) + (bvg_pkg::EmaW+3)'(v_ff) +
                (bvg_pkg::EmaW+3)'(2);
      pct_num = {1'b0, pnum_ff} + (PnumW+1)'(span >> 1);
      c_hi    = (ema_ff > hi) ? hi : ema_ff;
      mv_wide = {1'b0, c_ff} + (bvg_pkg::EmaW+1)'(128);

      state_in     = state_ff;
      rd_in        = rd_ff;
      prod_in      = prod_ff;
      v_in         = v_ff;
      ema_in       = ema_ff;
      seeded_in    = seeded_ff;
      eprod_in     = eprod_ff;
      c_in         = c_ff;
      pnum_in      = pnum_ff;
      mv_in        = mv_ff;
      pct_in       = pct_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_mv_in    = out_mv_ff;
      out_pct_in   = out_pct_ff;
      fifo_pop     = 1'b0;
      div_req      = '0;

      case (state_ff)
         bvg_pkg::BK_IDLE: begin
            if (!fifo_empty) begin
               fifo_pop = 1'b1;
               rd_in    = fifo_data;
               state_in = bvg_pkg::BK_MUL;
            end
         end
         bvg_pkg::BK_MUL: begin
            prod_in  = rd_ff.sum * cfg.gain;
            state_in = bvg_pkg::BK_AVG_START;
         end
         bvg_pkg::BK_AVG_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = avg_num[ProdW:8];
            div_req.divisor  = bvg_pkg::DivDenW'(rd_ff.count);
            state_in         = bvg_pkg::BK_AVG_WAIT;
         end
         bvg_pkg::BK_AVG_WAIT: begin
            if (div_rsp.done) begin
               v_in = (|div_rsp.quotient[bvg_pkg::DivNumW-1:bvg_pkg::EmaW]) ?
                      bvg_pkg::EmaMax : div_rsp.quotient[bvg_pkg::EmaW-1:0];
               state_in = bvg_pkg::BK_EMA;
            end
         end
         bvg_pkg::BK_EMA: begin
            if (seeded_ff) begin
               eprod_in = ema_num * bvg_pkg::EmaRecip;
               state_in = bvg_pkg::BK_EMA_WAIT;
            end else begin
               ema_in    = v_ff;
               seeded_in = 1'b1;
               state_in  = bvg_pkg::BK_CLAMP;
            end
         end
         bvg_pkg::BK_EMA_WAIT: begin
            ema_in   = eprod_ff[bvg_pkg::EmaShift+bvg_pkg::EmaW-1:bvg_pkg::EmaShift];
            state_in = bvg_pkg::BK_CLAMP;
         end
         bvg_pkg::BK_CLAMP: begin
            c_in     = (c_hi < lo) ? lo : c_hi;
            state_in = bvg_pkg::BK_PCT_MUL;
         end
         bvg_pkg::BK_PCT_MUL: begin
            pnum_in = (c_ff - lo) * bvg_pkg::PctMax;
            mv_in   = mv_wide[bvg_pkg::EmaW] ? bvg_pkg::SumMax : mv_wide[bvg_pkg::EmaW-1:8];
            if (cfg.full > cfg.empty) begin
               state_in = bvg_pkg::BK_PCT_START;
            end else begin
               pct_in   = '0;
               state_in = bvg_pkg::BK_OUT;
            end
         end
         bvg_pkg::BK_PCT_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = bvg_pkg::DivNumW'(pct_num);
            div_req.divisor  = span;
            state_in         = bvg_pkg::BK_PCT_WAIT;
         end
         bvg_pkg::BK_PCT_WAIT: begin
            if (div_rsp.done) begin
               pct_in   = (div_rsp.quotient > bvg_pkg::DivNumW'(bvg_pkg::PctMax)) ?
                          bvg_pkg::PctMax : div_rsp.quotient[bvg_pkg::PctW-1:0];
               state_in = bvg_pkg::BK_OUT;
            end
         end
         bvg_pkg::BK_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_mv_in    = mv_ff;
               out_pct_in   = pct_ff;
               state_in     = bvg_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = bvg_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bvg_pkg::BK_IDLE;
         seeded_ff    <= 1'b0;
         ema_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         ema_ff       <= ema_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff      <= rd_in;
      prod_ff    <= prod_in;
      v_ff       <= v_in;
      eprod_ff   <= eprod_in;
      c_ff       <= c_in;
      pnum_ff    <= pnum_in;
      mv_ff      <= mv_in;
      pct_ff     <= pct_in;
      out_mv_ff  <= out_mv_in;
      out_pct_ff <= out_pct_in;
   end

endmodule
